// ===== hdl/ssi_pkg.sv =====
`timescale 1ns / 1ps
// shared constants for the segment / sphere intersection core
// no dependencies
package ssi_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int RADIUS_BITS    = 15;
  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 15'd256;
  localparam int R2_BITS        = 2 * RADIUS_BITS;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_BITS      = 1;
  localparam int QCNT_BITS      = 2;

endpackage

// ===== hdl/ssi_if.sv =====
`timescale 1ns / 1ps
// valid / ready channel interfaces for the segment / sphere core
// depends on ssi_pkg for the default coordinate width
interface ssi_in_if #(
  parameter int COORD_BITS = ssi_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] seg_start_x;
  logic signed [COORD_BITS-1:0] seg_start_y;
  logic signed [COORD_BITS-1:0] seg_start_z;
  logic signed [COORD_BITS-1:0] seg_end_x;
  logic signed [COORD_BITS-1:0] seg_end_y;
  logic signed [COORD_BITS-1:0] seg_end_z;
  logic signed [COORD_BITS-1:0] ball_x;
  logic signed [COORD_BITS-1:0] ball_y;
  logic signed [COORD_BITS-1:0] ball_z;

  modport source (
    output valid, seg_start_x, seg_start_y, seg_start_z,
    output seg_end_x, seg_end_y, seg_end_z, ball_x, ball_y, ball_z,
    input  ready
  );
  modport sink (
    input  valid, seg_start_x, seg_start_y, seg_start_z,
    input  seg_end_x, seg_end_y, seg_end_z, ball_x, ball_y, ball_z,
    output ready
  );
endinterface

interface ssi_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic degenerate;

  modport source (output valid, hit, degenerate, input ready);
  modport sink (input valid, hit, degenerate, output ready);
endinterface

// ===== hdl/ssi_front.sv =====
`timescale 1ns / 1ps
// front pipeline: differences, products and dot products per item
// depends on ssi_pkg and ssi_in_if
module ssi_front #(
  parameter int COORD_BITS = ssi_pkg::COORD_BITS_DEF,
  parameter int SW         = 2 * COORD_BITS + 3,
  parameter int CW         = ((SW > ssi_pkg::R2_BITS + 1) ? SW : ssi_pkg::R2_BITS + 1) + 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [ssi_pkg::RADIUS_BITS-1:0]     radius,
  ssi_in_if.sink                              in_ch,
  output logic                                fr_valid,
  input  logic                                fr_ready,
  output logic                                fr_deg,
  output logic signed [SW-1:0]                fr_a,
  output logic signed [SW-1:0]                fr_fd,
  output logic signed [CW-1:0]                fr_cc
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;
  localparam int R2W = ssi_pkg::R2_BITS;

  logic signed [COORD_BITS-1:0] p1 [3];
  logic signed [COORD_BITS-1:0] p2 [3];
  logic signed [COORD_BITS-1:0] q  [3];

  logic                va_r, vb_r, vc_r;
  logic                adv_a, adv_b, adv_c;
  logic signed [DW-1:0] d_r [3];
  logic signed [DW-1:0] f_r [3];
  logic                deg_a_r, deg_b_r, deg_c_r;
  logic signed [PW-1:0] dd_r [3];
  logic signed [PW-1:0] fd_r [3];
  logic signed [PW-1:0] ff_r [3];
  logic [R2W-1:0]       r2_r;
  logic signed [SW-1:0] a_r, fds_r;
  logic signed [CW-1:0] cc_r;
  logic signed [SW-1:0] ff_sum;

  assign p1[0] = in_ch.seg_start_x;
  assign p1[1] = in_ch.seg_start_y;
  assign p1[2] = in_ch.seg_start_z;
  assign p2[0] = in_ch.seg_end_x;
  assign p2[1] = in_ch.seg_end_y;
  assign p2[2] = in_ch.seg_end_z;
  assign q[0]  = in_ch.ball_x;
  assign q[1]  = in_ch.ball_y;
  assign q[2]  = in_ch.ball_z;

  assign adv_c = !vc_r || fr_ready;
  assign adv_b = !vb_r || adv_c;
  assign adv_a = !va_r || adv_b;
  assign in_ch.ready = adv_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (adv_a) va_r <= in_ch.valid;
      if (adv_b) vb_r <= va_r;
      if (adv_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i] <= DW'(p2[i]) - DW'(p1[i]);
        f_r[i] <= DW'(p1[i]) - DW'(q[i]);
      end
      deg_a_r <= (p1[0] == p2[0]) && (p1[1] == p2[1]) && (p1[2] == p2[2]);
    end
    if (adv_b) begin
      for (int i = 0; i < 3; i++) begin
        dd_r[i] <= PW'(d_r[i]) * PW'(d_r[i]);
        fd_r[i] <= PW'(f_r[i]) * PW'(d_r[i]);
        ff_r[i] <= PW'(f_r[i]) * PW'(f_r[i]);
      end
      r2_r    <= R2W'(radius) * R2W'(radius);
      deg_b_r <= deg_a_r;
    end
    if (adv_c) begin
      a_r     <= SW'(dd_r[0]) + SW'(dd_r[1]) + SW'(dd_r[2]);
      fds_r   <= SW'(fd_r[0]) + SW'(fd_r[1]) + SW'(fd_r[2]);
      cc_r    <= CW'(ff_sum) - $signed(CW'(r2_r));
      deg_c_r <= deg_b_r;
    end
  end

  assign ff_sum = SW'(ff_r[0]) + SW'(ff_r[1]) + SW'(ff_r[2]);

  assign fr_valid = vc_r;
  assign fr_deg   = deg_c_r;
  assign fr_a     = a_r;
  assign fr_fd    = fds_r;
  assign fr_cc    = cc_r;

endmodule

// ===== hdl/ssi_queue.sv =====
`timescale 1ns / 1ps
// two-entry queue between the front and back pipelines
// depends on ssi_pkg
module ssi_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0]                  mem [ssi_pkg::QUEUE_DEPTH];
  logic [ssi_pkg::QPTR_BITS-1:0]     wr_ptr_r, rd_ptr_r;
  logic [ssi_pkg::QCNT_BITS-1:0]     cnt_r, cnt_nxt;
  logic                              push, pop;

  assign wr_ready = (cnt_r != ssi_pkg::QCNT_BITS'(ssi_pkg::QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_data;
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ssi_pkg::QCNT_BITS'(ssi_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count missed a transfer");
  a_pop_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("queue count missed a read");

endmodule

// ===== hdl/ssi_back.sv =====
`timescale 1ns / 1ps
// back pipeline: root classification and discriminant compare
// depends on ssi_pkg and ssi_out_if
module ssi_back #(
  parameter int COORD_BITS = ssi_pkg::COORD_BITS_DEF,
  parameter int SW         = 2 * COORD_BITS + 3,
  parameter int CW         = ((SW > ssi_pkg::R2_BITS + 1) ? SW : ssi_pkg::R2_BITS + 1) + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 bk_valid,
  output logic                 bk_ready,
  input  logic                 bk_deg,
  input  logic signed [SW-1:0] bk_a,
  input  logic signed [SW-1:0] bk_fd,
  input  logic signed [CW-1:0] bk_cc,
  ssi_out_if.source            out_ch
);

  localparam int GW  = CW + 2;
  localparam int MW  = 2 * COORD_BITS + 2;
  localparam int H   = COORD_BITS + 1;
  localparam int PPW = 2 * MW;

  logic                 vd_r, ve_r, adv_d, adv_e;
  logic signed [GW-1:0] g1;
  logic signed [SW:0]   afd, neg_fd;
  logic                 cc_neg, g1_neg, early, cand;
  logic [MW-1:0]        fdm, am, ccm;
  logic                 deg_d_r, early_d_r, cand_d_r;
  logic [2*H-1:0]       sq_hh_r, sq_hl_r, sq_lh_r, sq_ll_r;
  logic [2*H-1:0]       ac_hh_r, ac_hl_r, ac_lh_r, ac_ll_r;
  logic [PPW-1:0]       sq, ac;
  logic                 hit_e_r, deg_e_r;

  assign adv_e    = !ve_r || out_ch.ready;
  assign adv_d    = !vd_r || adv_e;
  assign bk_ready = adv_d;

  // g(1) = a + 2 f.d + c
  assign g1     = GW'(bk_a) + GW'(bk_fd) + GW'(bk_fd) + GW'(bk_cc);
  assign cc_neg = bk_cc[CW-1];
  assign g1_neg = g1[GW-1];
  assign afd    = (SW+1)'(bk_a) + (SW+1)'(bk_fd);
  assign neg_fd = -(SW+1)'(bk_fd);
  assign early  = !bk_deg && ((bk_cc == '0) || (g1 == '0) || (cc_neg != g1_neg));
  // both ends outside: vertex must sit in [0,1] and the discriminant be non-negative
  assign cand   = !bk_deg && !early && !cc_neg && (bk_fd[SW-1] || (bk_fd == '0))
                  && !afd[SW];
  assign fdm    = neg_fd[MW-1:0];
  assign am     = bk_a[MW-1:0];
  assign ccm    = bk_cc[MW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else begin
      if (adv_d) vd_r <= bk_valid;
      if (adv_e) ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_d) begin
      deg_d_r   <= bk_deg;
      early_d_r <= early;
      cand_d_r  <= cand;
      sq_hh_r   <= (2*H)'(fdm[MW-1:H]) * (2*H)'(fdm[MW-1:H]);
      sq_hl_r   <= (2*H)'(fdm[MW-1:H]) * (2*H)'(fdm[H-1:0]);
      sq_lh_r   <= (2*H)'(fdm[H-1:0]) * (2*H)'(fdm[MW-1:H]);
      sq_ll_r   <= (2*H)'(fdm[H-1:0]) * (2*H)'(fdm[H-1:0]);
      ac_hh_r   <= (2*H)'(am[MW-1:H]) * (2*H)'(ccm[MW-1:H]);
      ac_hl_r   <= (2*H)'(am[MW-1:H]) * (2*H)'(ccm[H-1:0]);
      ac_lh_r   <= (2*H)'(am[H-1:0]) * (2*H)'(ccm[MW-1:H]);
      ac_ll_r   <= (2*H)'(am[H-1:0]) * (2*H)'(ccm[H-1:0]);
    end
    if (adv_e) begin
      deg_e_r <= deg_d_r;
      hit_e_r <= early_d_r || (cand_d_r && (sq >= ac));
    end
  end

  assign sq = (PPW'(sq_hh_r) << (2*H)) + ((PPW'(sq_hl_r) + PPW'(sq_lh_r)) << H)
              + PPW'(sq_ll_r);
  assign ac = (PPW'(ac_hh_r) << (2*H)) + ((PPW'(ac_hl_r) + PPW'(ac_lh_r)) << H)
              + PPW'(ac_ll_r);

  assign out_ch.valid      = ve_r;
  assign out_ch.hit        = hit_e_r;
  assign out_ch.degenerate = deg_e_r;

  a_deg_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (ve_r && deg_e_r) |-> !hit_e_r)
    else $error("degenerate segment reported a hit");
  a_early_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (vd_r && early_d_r && adv_e) |=> hit_e_r)
    else $error("endpoint straddle lost its hit");
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    vd_r |-> !(early_d_r && cand_d_r) && !(deg_d_r && (early_d_r || cand_d_r)))
    else $error("classification flags overlap");

endmodule

// ===== hdl/segment_sphere_intersect_core.sv =====
`timescale 1ns / 1ps
// top level of the segment / sphere surface intersection core
// depends on ssi_pkg, ssi_if, ssi_front, ssi_queue and ssi_back
//
// in_ch carries one segment (start, end) and a ball centre per transfer, all
// signed Q8.8; out_ch returns hit and degenerate for each item, in order.
// cfg_wr_en / cfg_wr_data load the ball radius (unsigned Q7.8), reset 1.0;
// write it only while no item is in flight.
// one item per cycle is taken and one result per cycle given when out_ch is
// not stalled. the result passes through three front stages (differences,
// products, dot sums), the queue and two back stages (classification with
// split partial products, then the discriminant compare).
// a stall on out_ch holds the output register; items keep flowing until both
// back stages, the two-entry queue and the three front stages are full
// (seven items in flight), then in_ch.ready drops.
// reset empties every stage and the queue and sets the radius to 1.0.
module segment_sphere_intersect_core #(
  parameter int COORD_BITS = ssi_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ssi_in_if.sink                          in_ch,
  ssi_out_if.source                       out_ch,
  input  logic                            cfg_wr_en,
  input  logic [ssi_pkg::RADIUS_BITS-1:0] cfg_wr_data
);

  localparam int SW = 2 * COORD_BITS + 3;
  localparam int CW = ((SW > ssi_pkg::R2_BITS + 1) ? SW : ssi_pkg::R2_BITS + 1) + 1;
  localparam int QW = 1 + 2 * SW + CW;

  logic [ssi_pkg::RADIUS_BITS-1:0] radius_r;
  logic                 fr_valid, fr_ready, fr_deg;
  logic signed [SW-1:0] fr_a, fr_fd;
  logic signed [CW-1:0] fr_cc;
  logic [QW-1:0]        q_wr_data, q_rd_data;
  logic                 bk_valid, bk_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= ssi_pkg::RADIUS_RESET;
    end else if (cfg_wr_en) begin
      radius_r <= cfg_wr_data;
    end
  end

  ssi_front #(.COORD_BITS(COORD_BITS), .SW(SW), .CW(CW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .radius   (radius_r),
    .in_ch    (in_ch),
    .fr_valid (fr_valid),
    .fr_ready (fr_ready),
    .fr_deg   (fr_deg),
    .fr_a     (fr_a),
    .fr_fd    (fr_fd),
    .fr_cc    (fr_cc)
  );

  assign q_wr_data = {fr_deg, fr_a, fr_fd, fr_cc};

  ssi_queue #(.WIDTH(QW)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_data  (q_wr_data),
    .rd_valid (bk_valid),
    .rd_ready (bk_ready),
    .rd_data  (q_rd_data)
  );

  ssi_back #(.COORD_BITS(COORD_BITS), .SW(SW), .CW(CW)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .bk_valid (bk_valid),
    .bk_ready (bk_ready),
    .bk_deg   (q_rd_data[QW-1]),
    .bk_a     ($signed(q_rd_data[QW-2 -: SW])),
    .bk_fd    ($signed(q_rd_data[CW+SW-1 -: SW])),
    .bk_cc    ($signed(q_rd_data[CW-1:0])),
    .out_ch   (out_ch)
  );

endmodule
